// ----- hw/rtl/glmf_pkg.sv -----
// Package with the shared constants, types and helper functions of the grid local minimum finder.
package glmf_pkg;

  // Raster geometry: columns are indexed by COL_W bits, and the row width register by WIDTH_W bits.
  localparam int MAX_COLUMNS = 64;
  localparam int COL_W       = 6;
  localparam int WIDTH_W     = 7;
  localparam int HEIGHT_W    = 4;
  localparam int ROW_W       = 16;
  localparam int RISK_W      = 24;

  typedef logic [COL_W-1:0]    col_t;
  typedef logic [WIDTH_W-1:0]  width_t;
  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [RISK_W-1:0]   risk_t;

  localparam row_t   ROW_MAX         = '1;
  localparam risk_t  RISK_MAX        = '1;
  localparam width_t RESET_ROW_WIDTH = WIDTH_W'(MAX_COLUMNS);

  // Item kinds carried by the mode field.
  typedef enum logic {
    MODE_CELL  = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

  // A width of zero acts as one column, and a width beyond the buffers acts as the buffer depth.
  function automatic width_t eff_width(input width_t w);
    width_t res;
    res = w;
    if (w == '0) begin
      res = WIDTH_W'(1);
    end else if (w > WIDTH_W'(MAX_COLUMNS)) begin
      res = WIDTH_W'(MAX_COLUMNS);
    end
    return res;
  endfunction

  // Adds height plus one to the risk total and saturates at its maximum.
  function automatic risk_t risk_add(input risk_t risk, input height_t h);
    logic [RISK_W:0] sum;
    sum = {1'b0, risk} + (RISK_W+1)'(h) + (RISK_W+1)'(1);
    return sum[RISK_W] ? RISK_MAX : sum[RISK_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/grid_local_minimum_finder.sv -----
// Top level of the grid local minimum finder: line buffers, sequencer and result register.

// Heights stream in row order, one cell per input transfer; a cell's verdict (strictly below every
// existing 4-neighbor) comes out when the cell below it arrives, together with the running,
// saturating risk total. For a height cell, the accept state reads both line buffers, and S_CELL
// then judges the cell above, writes the buffers back and loads the result register once it is free.
// A flush judges the remaining columns of the last complete row in S_FLUSH (one result per cycle
// while the result register is free, since each verdict needs one read of the line buffers), or
// goes to S_MARK when only the end-of-frame marker is due. The result register lets the next item
// in while a result waits; a full register stalls the sequencer. The line buffers need no clearing
// pass after reset, and the row width register should only be written while the block is idle.
module grid_local_minimum_finder
  import glmf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [HEIGHT_W-1:0] in_height,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [COL_W-1:0]    out_col,
  output logic [ROW_W-1:0]    out_row,
  output logic [HEIGHT_W-1:0] out_cell_height,
  output logic                out_is_low,
  output logic [RISK_W-1:0]   out_risk_total,
  output logic                out_last,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WIDTH_W-1:0]  cfg_row_width
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_FLUSH,
    S_MARK
  } state_t;

  // Line buffers: the row above the judged row, and the judged row itself.
  height_t upper_mem [MAX_COLUMNS];
  height_t middle_mem [MAX_COLUMNS];

  state_t  state_r, state_nxt;
  width_t  row_width_r, row_width_nxt;
  width_t  col_count_r, col_count_nxt;
  row_t    row_count_r, row_count_nxt;
  risk_t   risk_sum_r, risk_sum_nxt;
  height_t left_hold_r, left_hold_nxt;
  height_t flush_left_r, flush_left_nxt;
  col_t    cur_c_r, cur_c_nxt;
  height_t cell_h_r, cell_h_nxt;

  logic    out_valid_r, out_valid_nxt;
  col_t    out_col_r, out_col_nxt;
  row_t    out_row_r, out_row_nxt;
  height_t out_height_r, out_height_nxt;
  logic    out_low_r, out_low_nxt;
  risk_t   out_risk_r, out_risk_nxt;
  logic    out_last_r, out_last_nxt;

  // Registered read data of the line buffers.
  height_t mid_q0_r;
  height_t mid_q1_r;
  height_t up_q_r;

  logic    rd_en;
  col_t    rd_addr;
  logic    wr_en;

  width_t  w;
  width_t  w_m1;
  col_t    c_start;
  width_t  next_col;
  logic    has_up;
  logic    has_dn;
  logic    has_l;
  logic    has_r;
  height_t left_val;
  logic    is_low;
  risk_t   risk_new;
  logic    out_free;
  logic    flush_due;

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_col         = out_col_r;
  assign out_row         = out_row_r;
  assign out_cell_height = out_height_r;
  assign out_is_low      = out_low_r;
  assign out_risk_total  = out_risk_r;
  assign out_last        = out_last_r;

  // Effective width and the column that the next cell lands in.
  assign w         = eff_width(row_width_r);
  assign w_m1      = w - WIDTH_W'(1);
  assign c_start   = (col_count_r >= w) ? w_m1[COL_W-1:0] : col_count_r[COL_W-1:0];
  assign flush_due = (row_count_r != '0) && (col_count_r < w);
  assign out_free  = !out_valid_r || out_ready;

  // Neighbor tests for the cell at cur_c_r of the judged row.
  assign next_col = {1'b0, cur_c_r} + WIDTH_W'(1);
  assign has_up   = (row_count_r >= ROW_W'(2));
  assign has_dn   = (state_r == S_CELL);
  assign has_l    = (cur_c_r != '0);
  assign has_r    = (next_col < w);
  assign left_val = (state_r == S_CELL) ? left_hold_r : flush_left_r;
  assign is_low   = (!has_up || (mid_q0_r < up_q_r)) &&
                    (!has_dn || (mid_q0_r < cell_h_r)) &&
                    (!has_l  || (mid_q0_r < left_val)) &&
                    (!has_r  || (mid_q0_r < mid_q1_r));
  assign risk_new = is_low ? risk_add(risk_sum_r, mid_q0_r) : risk_sum_r;

  // Upper line buffer: one read port and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[cur_c_r] <= mid_q0_r;
    end
    if (rd_en) begin
      up_q_r <= upper_mem[rd_addr];
    end
  end

  // Middle line buffer: reads the judged column and its right neighbor, writes the new cell.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      middle_mem[cur_c_r] <= cell_h_r;
    end
    if (rd_en) begin
      mid_q0_r <= middle_mem[rd_addr];
      mid_q1_r <= middle_mem[rd_addr + COL_W'(1)];
    end
  end

  // Sequencer and result register next values.
  always_comb begin
    state_nxt      = state_r;
    row_width_nxt  = row_width_r;
    col_count_nxt  = col_count_r;
    row_count_nxt  = row_count_r;
    risk_sum_nxt   = risk_sum_r;
    left_hold_nxt  = left_hold_r;
    flush_left_nxt = flush_left_r;
    cur_c_nxt      = cur_c_r;
    cell_h_nxt     = cell_h_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_height_nxt = out_height_r;
    out_low_nxt    = out_low_r;
    out_risk_nxt   = out_risk_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = c_start;
    wr_en          = 1'b0;

    // The width register is written by its own transfer.
    if (cfg_valid) begin
      row_width_nxt = cfg_row_width;
    end

    unique case (state_r)
      // Take an item and start the line buffer reads for its column.
      S_IDLE: begin
        if (in_valid) begin
          rd_en     = 1'b1;
          rd_addr   = c_start;
          cur_c_nxt = c_start;
          if (mode_t'(in_mode) == MODE_CELL) begin
            cell_h_nxt = in_height;
            state_nxt  = S_CELL;
          end else if (flush_due) begin
            flush_left_nxt = left_hold_r;
            state_nxt      = S_FLUSH;
          end else begin
            state_nxt = S_MARK;
          end
        end
      end

      // Judge the cell above the new one, then shift the column down the line buffers.
      S_CELL: begin
        if ((row_count_r == '0) || out_free) begin
          wr_en         = 1'b1;
          left_hold_nxt = mid_q0_r;
          if (row_count_r != '0) begin
            out_valid_nxt  = 1'b1;
            out_col_nxt    = cur_c_r;
            out_row_nxt    = row_count_r - ROW_W'(1);
            out_height_nxt = mid_q0_r;
            out_low_nxt    = is_low;
            out_risk_nxt   = risk_new;
            out_last_nxt   = 1'b0;
            risk_sum_nxt   = risk_new;
          end
          if (next_col >= w) begin
            col_count_nxt = '0;
            if (row_count_r != ROW_MAX) begin
              row_count_nxt = row_count_r + ROW_W'(1);
            end
          end else begin
            col_count_nxt = next_col;
          end
          state_nxt = S_IDLE;
        end
      end

      // Judge the remaining columns of the last complete row, one per cycle while the result register is free.
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_col_nxt    = cur_c_r;
          out_row_nxt    = row_count_r - ROW_W'(1);
          out_height_nxt = mid_q0_r;
          out_low_nxt    = is_low;
          out_risk_nxt   = risk_new;
          out_last_nxt   = !has_r;
          risk_sum_nxt   = risk_new;
          if (has_r) begin
            rd_en          = 1'b1;
            rd_addr        = next_col[COL_W-1:0];
            cur_c_nxt      = next_col[COL_W-1:0];
            flush_left_nxt = mid_q0_r;
          end else begin
            left_hold_nxt = '0;
            col_count_nxt = '0;
            row_count_nxt = '0;
            risk_sum_nxt  = '0;
            state_nxt     = S_IDLE;
          end
        end
      end

      // Nothing left to judge: a single end-of-frame marker.
      S_MARK: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_col_nxt    = '0;
          out_row_nxt    = '0;
          out_height_nxt = '0;
          out_low_nxt    = 1'b0;
          out_risk_nxt   = risk_sum_r;
          out_last_nxt   = 1'b1;
          left_hold_nxt  = '0;
          col_count_nxt  = '0;
          row_count_nxt  = '0;
          risk_sum_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, frame counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_width_r  <= RESET_ROW_WIDTH;
      col_count_r  <= '0;
      row_count_r  <= '0;
      risk_sum_r   <= '0;
      left_hold_r  <= '0;
      flush_left_r <= '0;
      cur_c_r      <= '0;
      cell_h_r     <= '0;
      out_valid_r  <= 1'b0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_height_r <= '0;
      out_low_r    <= 1'b0;
      out_risk_r   <= '0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_width_r  <= row_width_nxt;
      col_count_r  <= col_count_nxt;
      row_count_r  <= row_count_nxt;
      risk_sum_r   <= risk_sum_nxt;
      left_hold_r  <= left_hold_nxt;
      flush_left_r <= flush_left_nxt;
      cur_c_r      <= cur_c_nxt;
      cell_h_r     <= cell_h_nxt;
      out_valid_r  <= out_valid_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      out_height_r <= out_height_nxt;
      out_low_r    <= out_low_nxt;
      out_risk_r   <= out_risk_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

endmodule

// ----- tb/sv/grid_local_minimum_finder_tb.sv -----
// Self-checking testbench for the grid local minimum finder.
`timescale 1ns / 1ps

module grid_local_minimum_finder_tb
  import glmf_pkg::*;
;

  localparam int HOLD_CYCLES       = 400;
  localparam int QUIET_LIMIT       = 3000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int TAIL_CYCLES       = 20;
  localparam int MAX_REPORTS       = 10;

  // One verdict as it leaves the result channel.
  typedef struct packed {
    col_t    col;
    row_t    row;
    height_t cell_height;
    logic    is_low;
    risk_t   risk_total;
    logic    last;
  } verdict_t;

  // Tracks the raster state of the block and the verdicts that are still due.
  class lowpoint_scoreboard;
    height_t     upper_row[MAX_COLUMNS];
    height_t     middle_row[MAX_COLUMNS];
    height_t     left_cell;
    int unsigned col_pos;
    int unsigned rows_done;
    risk_t       risk_acc;
    width_t      width_reg;
    verdict_t    due_verdicts[$];
    int unsigned failures;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      left_cell = '0;
      col_pos   = 0;
      rows_done = 0;
      risk_acc  = '0;
      width_reg = width_t'(MAX_COLUMNS);
      failures  = 0;
    endfunction

    // Number of columns that a register value stands for.
    static function int unsigned columns_for(width_t w);
      if (w == '0) begin
        return 1;
      end
      if (w > width_t'(MAX_COLUMNS)) begin
        return MAX_COLUMNS;
      end
      return 32'(w);
    endfunction

    function void set_row_width(width_t w);
      width_reg = w;
    endfunction

    function int unsigned due_count();
      return due_verdicts.size();
    endfunction

    // Judges one cell against the neighbors that exist and updates the risk total.
    function verdict_t judge(int unsigned c, height_t h, bit has_up, height_t up,
                             bit has_dn, height_t dn, bit has_l, height_t l,
                             bit has_r, height_t r);
      verdict_t         v;
      logic [RISK_W:0]  sum;
      v.is_low = (!has_up || h < up) && (!has_dn || h < dn) &&
                 (!has_l || h < l) && (!has_r || h < r);
      if (v.is_low) begin
        sum      = {1'b0, risk_acc} + (RISK_W+1)'(h) + (RISK_W+1)'(1);
        risk_acc = sum[RISK_W] ? RISK_MAX : sum[RISK_W-1:0];
      end
      v.col         = col_t'(c);
      v.row         = row_t'(rows_done - 1);
      v.cell_height = h;
      v.risk_total  = risk_acc;
      v.last        = 1'b0;
      return v;
    endfunction

    // Works out the verdicts caused by one accepted input transfer.
    function void note_item(mode_t m, height_t h);
      int unsigned w;
      int unsigned c;
      height_t     old;
      height_t     l;
      height_t     r;
      verdict_t    marker;
      int          produced;
      w        = columns_for(width_reg);
      produced = 0;
      if (m == MODE_CELL) begin
        c = (col_pos >= w) ? w - 1 : col_pos;
        if (rows_done >= 1) begin
          r = (c + 1 < w) ? middle_row[col_t'(c + 1)] : '0;
          due_verdicts = {due_verdicts,
                          judge(c, middle_row[col_t'(c)], rows_done >= 2,
                                upper_row[col_t'(c)], 1'b1, h, c > 0, left_cell,
                                c + 1 < w, r)};
        end
        old                   = middle_row[col_t'(c)];
        upper_row[col_t'(c)]  = old;
        left_cell             = old;
        middle_row[col_t'(c)] = h;
        if (c + 1 >= w) begin
          col_pos = 0;
          if (rows_done < ROW_MAX) begin
            rows_done++;
          end
        end else begin
          col_pos = c + 1;
        end
      end else begin
        // The flush judges the rest of the last complete row, with nothing below it.
        if (rows_done >= 1) begin
          for (c = col_pos; c < w; c++) begin
            if (c == 0) begin
              l = '0;
            end else if (c == col_pos) begin
              l = left_cell;
            end else begin
              l = middle_row[col_t'(c - 1)];
            end
            r = (c + 1 < w) ? middle_row[col_t'(c + 1)] : '0;
            due_verdicts = {due_verdicts,
                            judge(c, middle_row[col_t'(c)], rows_done >= 2,
                                  upper_row[col_t'(c)], 1'b0, '0, c > 0, l,
                                  c + 1 < w, r)};
            produced++;
          end
        end
        if (produced == 0) begin
          marker            = '0;
          marker.risk_total = risk_acc;
          due_verdicts      = {due_verdicts, marker};
        end
        due_verdicts[due_verdicts.size() - 1].last = 1'b1;
        left_cell = '0;
        col_pos   = 0;
        rows_done = 0;
        risk_acc  = '0;
      end
    endfunction

    function string describe(verdict_t v);
      return $sformatf("col=%0d row=%0d height=%0d low=%0d risk=%0d last=%0d",
                       v.col, v.row, v.cell_height, v.is_low, v.risk_total, v.last);
    endfunction

    // Compares one output transfer with the oldest verdict that is due.
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (due_verdicts.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("[%0t] unexpected result: %s", $time, describe(got));
        end
        return;
      end
      want = due_verdicts.pop_front();
      if (got.col !== want.col || got.row !== want.row ||
          got.cell_height !== want.cell_height || got.is_low !== want.is_low ||
          got.risk_total !== want.risk_total || got.last !== want.last) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("[%0t] verdict mismatch: expected %s, got %s", $time,
                   describe(want), describe(got));
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_mode = 1'b0;
  logic [HEIGHT_W-1:0] in_height = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    out_row;
  logic [HEIGHT_W-1:0] out_cell_height;
  logic                out_is_low;
  logic [RISK_W-1:0]   out_risk_total;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WIDTH_W-1:0]  cfg_row_width = '0;

  lowpoint_scoreboard sb;
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned random_items = 0;
  int unsigned quiet_cycles = 0;

  grid_local_minimum_finder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_height       (in_height),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_cell_height (out_cell_height),
    .out_is_low      (out_is_low),
    .out_risk_total  (out_risk_total),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_row_width   (cfg_row_width)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, or for one long stretch when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Every output transfer is checked against the oldest due verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_verdict('{out_col, out_row, out_cell_height, out_is_low, out_risk_total,
                         out_last});
    end
  end

  // The run ends if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, with random idle cycles ahead of it, and waits for its transfer.
  task automatic send_item(mode_t m, height_t h);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= m;
    in_height <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(m, h);
  endtask

  // Stops offering items until every due verdict has come, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(width_t w);
    cfg_valid     <= 1'b1;
    cfg_row_width <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_row_width(w);
    cfg_valid <= 1'b0;
  endtask

  // One frame: full rows and a trailing partial row of cells, closed by a flush.
  task automatic run_frame(width_t reg_val, int unsigned rows, int unsigned tail, bit narrow);
    int unsigned cells;
    height_t     base;
    drain();
    write_row_width(reg_val);
    cells = rows * lowpoint_scoreboard::columns_for(reg_val) + tail;
    base  = height_t'($urandom_range(0, 13));
    for (int unsigned n = 0; n < cells; n++) begin
      // Narrow frames cluster heights so that ties between neighbors are common.
      send_item(MODE_CELL, narrow ? height_t'(base + $urandom_range(0, 2))
                                  : height_t'($urandom_range(0, 15)));
    end
    send_item(MODE_FLUSH, height_t'($urandom_range(0, 15)));
    random_items += cells + 1;
  endtask

  // Wide frames keep to at most one row and a short tail so that the run stays small.
  task automatic random_frame(width_t reg_val);
    int unsigned cols;
    int unsigned rows;
    int unsigned tail;
    cols = lowpoint_scoreboard::columns_for(reg_val);
    if ($urandom_range(0, 99) < 12) begin
      rows = 0;
    end else begin
      rows = (cols <= 16) ? $urandom_range(1, 4) : 1;
    end
    if (cols > 16) begin
      tail = ($urandom_range(0, 99) < 40) ? $urandom_range(1, 3) : 0;
    end else begin
      tail = (cols > 1 && $urandom_range(0, 99) < 40) ? $urandom_range(1, cols - 1) : 0;
    end
    run_frame(reg_val, rows, tail, 1'($urandom_range(0, 1)));
  endtask

  // Mostly narrow rows; now and then a zero width or one at or beyond the buffer depth.
  function automatic width_t pick_width();
    case ($urandom_range(0, 19))
      0:       return width_t'(0);
      1:       return width_t'(1);
      2:       return width_t'(127);
      3:       return width_t'(MAX_COLUMNS);
      4:       return width_t'($urandom_range(65, 126));
      default: return width_t'($urandom_range(2, 9));
    endcase
  endfunction

  task automatic random_phase(width_t first_width, int unsigned quota);
    int unsigned start;
    start = random_items;
    random_frame(first_width);
    while (random_items - start < quota) begin
      random_frame(pick_width());
    end
  endtask

  task automatic send_cells(height_t cells[$]);
    foreach (cells[i]) begin
      send_item(MODE_CELL, cells[i]);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    in_idle_pct  = 17;
    out_idle_pct = 69;

    // A flush before any cell gives the end-of-frame marker alone.
    send_item(MODE_FLUSH, 4'hF);

    // Three columns: extremes, ties and a trailing partial row before the flush.
    drain();
    write_row_width(width_t'(3));
    send_cells('{4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd7, 4'd7, 4'd3, 4'd0, 4'd15});
    send_item(MODE_FLUSH, 4'd0);

    // A flush inside the first row has nothing to judge.
    send_cells('{4'd5, 4'd5});
    send_item(MODE_FLUSH, 4'd5);

    // A zero width acts as a single column.
    drain();
    write_row_width(width_t'(0));
    send_cells('{4'd0, 4'd15, 4'd7, 4'd15});
    send_item(MODE_FLUSH, 4'd0);

    random_phase(width_t'(127), 20);

    // Sender idles heavily, receiver lightly.
    drain();
    in_idle_pct  = 69;
    out_idle_pct = 17;
    random_phase(pick_width(), 12);

    // No idling; first the receiver holds off long enough for the block to stall its input.
    drain();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    drain();
    write_row_width(width_t'(8));
    hold_request = 1'b1;
    for (int n = 0; n < 24; n++) begin
      send_item(MODE_CELL, height_t'($urandom_range(0, 15)));
    end
    send_item(MODE_FLUSH, 4'd0);
    random_phase(pick_width(), 12);

    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.due_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/glmf_pkg.sv
hw/rtl/grid_local_minimum_finder.sv
tb/sv/grid_local_minimum_finder_tb.sv
